// File: src/assert_macros.svh
// Assertion macros used by pretrigger_capture_scope_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: src/pcs_pkg.sv
// Types and constants of the pretrigger capture scope.
package pcs_pkg;

   localparam int ADDR_BITS     = 8;
   localparam int SAMPLES       = 1 << ADDR_BITS;
   localparam int COUNT_BITS    = ADDR_BITS + 1;
   localparam int CHANNELS      = 4;
   localparam int OUT_CHANNELS  = 4;
   localparam int SAMPLE_BITS   = 32;
   localparam int CHAN_BITS     = 32;
   localparam int ROW_BITS      = CHANNELS * SAMPLE_BITS;
   localparam int INDEX_BITS    = 16;

   localparam int PCT_BITS      = 7;
   localparam int PCT_MAX       = 100;
   localparam int SCALED_BITS   = PCT_BITS + ADDR_BITS;
   // floor(x / 100) == (x * RECIP_MULT) >> RECIP_SHIFT for x below 2**19
   localparam int RECIP_SHIFT   = 26;
   localparam int RECIP_BITS    = 20;
   localparam int RECIP_MULT    = 671089;
   localparam int PROD_BITS     = SCALED_BITS + RECIP_BITS;

   localparam int REQ_DATA_BITS = 136;
   localparam int RSP_DATA_BITS = 152;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [2:0] {
      PH_STOP      = 3'd0,
      PH_ARMED     = 3'd1,
      PH_READY     = 3'd2,
      PH_TRIGGERED = 3'd3,
      PH_COMPLETE  = 3'd4,
      PH_READOUT   = 3'd5,
      PH_DAQ       = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_CONTROL = 2'd1,
      CMD_STATUS  = 2'd2
   } command_type;

   typedef enum logic [2:0] {
      CTL_STOP    = 3'd0,
      CTL_CAPTURE = 3'd1,
      CTL_READOUT = 3'd5,
      CTL_DAQ     = 3'd6
   } control_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_BUSY    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REG_DIVIDER = 2'd0,
      REG_PRETRIG = 2'd1,
      REG_SELECT  = 2'd2,
      REG_LEVEL   = 2'd3
   } reg_index_type;

   typedef enum logic {
      KIND_STATUS = 1'b0,
      KIND_SAMPLE = 1'b1
   } kind_type;

endpackage

// File: src/pcs_ram.sv
// Generic single-port-write, registered-read RAM.
module pcs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/pretrigger_capture_scope_core.sv
// Pretrigger capture scope: one request per cycle unless stalled, registered results.
// A request is accepted every cycle unless the result register and the stage
// before it are both full and rsp_tready is low; the sample store is read at
// acceptance and its data moves into the result register with that stage.
// No clearing pass: a valid bit per store row makes unwritten rows read as zero.
// Reset (synchronous, active high) clears phase, counters, registers and valid bits.
`include "assert_macros.svh"

module pretrigger_capture_scope_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // control_code, sink_accepted, channel_0, channel_1, channel_2, channel_3
   input  logic [pcs_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // command
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // status_code, scope_state, sample_index, out_channel_0..out_channel_3
   output logic [pcs_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // record_kind
   output logic                                rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pcs_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [pcs_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   localparam int AB = pcs_pkg::ADDR_BITS;
   localparam int CB = pcs_pkg::CHAN_BITS;
   localparam int SB = pcs_pkg::SAMPLE_BITS;
   localparam int NB = pcs_pkg::COUNT_BITS;
   localparam int IB = pcs_pkg::INDEX_BITS;

   // configuration
   logic [15:0]          div_m1_ff, div_m1_in;
   logic [NB-1:0]        pre_total_ff, pre_total_in;
   logic signed [3:0]    trig_sel_ff, trig_sel_in;
   logic signed [CB-1:0] trig_level_ff, trig_level_in;

   // scope state
   pcs_pkg::phase_type   phase_ff, phase_in;
   logic [AB-1:0]        wp_ff, wp_in;
   logic [15:0]          div_ff, div_in;
   logic [NB-1:0]        pre_ff, pre_in;
   logic [NB-1:0]        post_ff, post_in;
   logic [IB-1:0]        rp_ff, rp_in;
   logic [pcs_pkg::SAMPLES-1:0] row_valid_ff;

   // stage after acceptance
   logic                 a_valid_ff, a_valid_in;
   pcs_pkg::kind_type    a_kind_ff, a_kind_in;
   pcs_pkg::status_type  a_status_ff, a_status_in;
   pcs_pkg::phase_type   a_state_ff, a_state_in;
   logic [IB-1:0]        a_index_ff, a_index_in;
   logic                 a_from_mem_ff, a_from_mem_in;
   logic                 a_row_ok_ff, a_row_ok_in;
   logic [CB-1:0]        a_chan_ff [pcs_pkg::OUT_CHANNELS];
   logic [CB-1:0]        a_chan_in [pcs_pkg::OUT_CHANNELS];

   // result register
   logic                 b_valid_ff, b_valid_in;
   pcs_pkg::kind_type    b_kind_ff;
   pcs_pkg::status_type  b_status_ff;
   pcs_pkg::phase_type   b_state_ff;
   logic [IB-1:0]        b_index_ff;
   logic [CB-1:0]        b_chan_ff [pcs_pkg::OUT_CHANNELS];
   logic [CB-1:0]        b_chan_in [pcs_pkg::OUT_CHANNELS];

   // store port
   logic                      ram_we, ram_re;
   logic [AB-1:0]             ram_raddr;
   logic [pcs_pkg::ROW_BITS-1:0] ram_wdata, ram_q;

   logic                 accept, a_advance, csr_write, is_idle;
   pcs_pkg::command_type cmd;
   pcs_pkg::control_type code;
   logic                 sink;
   logic signed [CB-1:0] ext [pcs_pkg::OUT_CHANNELS];
   logic [3:0]           sel_mag, sel_ch;
   logic signed [CB-1:0] trig_val;
   logic                 trig_found, trig_hit;
   logic [pcs_pkg::PCT_BITS-1:0]  pct_sat;
   logic [pcs_pkg::PROD_BITS-1:0] pct_prod;

   assign cmd  = pcs_pkg::command_type'(req_tuser);
   assign code = pcs_pkg::control_type'(req_tdata[2:0]);
   assign sink = req_tdata[3];

   always_comb begin
      for (int j = 0; j < pcs_pkg::OUT_CHANNELS; j++) begin
         ext[j] = CB'($signed(req_tdata[4 + j*CB +: SB]));
      end
      for (int j = 0; j < pcs_pkg::CHANNELS; j++) begin
         ram_wdata[j*SB +: SB] = req_tdata[4 + j*CB +: SB];
      end
   end

   // trigger condition on the sample being stored
   always_comb begin
      sel_mag    = trig_sel_ff[3] ? 4'(-trig_sel_ff) : 4'(trig_sel_ff);
      sel_ch     = sel_mag - 4'd1;
      trig_val   = '0;
      trig_found = 1'b0;
      for (int j = 0; j < pcs_pkg::CHANNELS; j++) begin
         if (sel_ch == 4'(j)) begin
            trig_val   = ext[j];
            trig_found = 1'b1;
         end
      end
      if (trig_sel_ff == 4'sd0) begin
         trig_hit = 1'b1;
      end else if (trig_sel_ff[3]) begin
         trig_hit = trig_found && (trig_val <= trig_level_ff);
      end else begin
         trig_hit = trig_found && (trig_val >= trig_level_ff);
      end
   end

   // pre-trigger sample count from the written percentage
   always_comb begin
      pct_sat  = (csr_data[pcs_pkg::PCT_BITS-1:0] > pcs_pkg::PCT_BITS'(pcs_pkg::PCT_MAX))
               ? pcs_pkg::PCT_BITS'(pcs_pkg::PCT_MAX) : csr_data[pcs_pkg::PCT_BITS-1:0];
      pct_prod = pcs_pkg::PROD_BITS'({pct_sat, {AB{1'b0}}})
               * pcs_pkg::PROD_BITS'(pcs_pkg::RECIP_MULT);
   end

   assign is_idle    = (phase_ff == pcs_pkg::PH_STOP) || (phase_ff == pcs_pkg::PH_COMPLETE);
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready && is_idle;
   assign a_advance  = a_valid_ff && (!b_valid_ff || rsp_tready);
   assign req_tready = !a_valid_ff || a_advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      div_m1_in     = div_m1_ff;
      pre_total_in  = pre_total_ff;
      trig_sel_in   = trig_sel_ff;
      trig_level_in = trig_level_ff;
      if (csr_write) begin
         case (pcs_pkg::reg_index_type'(csr_index))
            pcs_pkg::REG_DIVIDER: div_m1_in = csr_data[15:0];
            pcs_pkg::REG_PRETRIG: pre_total_in = pct_prod[pcs_pkg::RECIP_SHIFT +: NB];
            pcs_pkg::REG_SELECT:  trig_sel_in = csr_data[3:0];
            pcs_pkg::REG_LEVEL:   trig_level_in = csr_data[CB-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [IB-1:0] rp_next;
      logic [AB-1:0] pos;
      pcs_pkg::phase_type ph;

      phase_in      = phase_ff;
      wp_in         = wp_ff;
      div_in        = div_ff;
      pre_in        = pre_ff;
      post_in       = post_ff;
      rp_in         = rp_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      pos           = (rp_ff < IB'(pcs_pkg::SAMPLES)) ? rp_ff[AB-1:0] : '0;
      ram_raddr     = pos + wp_ff;
      rp_next       = sink ? IB'(rp_ff + 1'b1) : rp_ff;
      ph            = phase_ff;
      a_kind_in     = pcs_pkg::KIND_STATUS;
      a_status_in   = pcs_pkg::ST_OK;
      a_index_in    = '0;
      a_from_mem_in = 1'b0;
      a_row_ok_in   = row_valid_ff[ram_raddr];
      for (int j = 0; j < pcs_pkg::OUT_CHANNELS; j++) begin
         a_chan_in[j] = '0;
      end
      a_valid_in    = a_advance ? 1'b0 : a_valid_ff;

      if (accept) begin
         case (cmd)
            pcs_pkg::CMD_TICK: begin
               if (phase_ff == pcs_pkg::PH_ARMED || phase_ff == pcs_pkg::PH_READY ||
                   phase_ff == pcs_pkg::PH_TRIGGERED || phase_ff == pcs_pkg::PH_DAQ) begin
                  if (div_ff != 16'd0) begin
                     div_in = div_ff - 16'd1;
                  end else begin
                     div_in = div_m1_ff;
                     ram_we = 1'b1;
                     wp_in  = wp_ff + 1'b1;
                     if (ph == pcs_pkg::PH_ARMED) begin
                        if (pre_ff != '0) pre_in = pre_ff - 1'b1;
                        else ph = pcs_pkg::PH_READY;
                     end
                     if (ph == pcs_pkg::PH_READY && trig_hit) begin
                        ph = pcs_pkg::PH_TRIGGERED;
                     end
                     if (ph == pcs_pkg::PH_TRIGGERED) begin
                        if (post_ff != '0) post_in = post_ff - 1'b1;
                        else ph = pcs_pkg::PH_COMPLETE;
                     end
                     if (ph == pcs_pkg::PH_DAQ) begin
                        a_valid_in = 1'b1;
                        a_kind_in  = pcs_pkg::KIND_SAMPLE;
                        a_index_in = rp_ff;
                        for (int j = 0; j < pcs_pkg::CHANNELS; j++) begin
                           a_chan_in[j] = ext[j];
                        end
                        rp_in = IB'(rp_ff + 1'b1);
                     end
                     phase_in = ph;
                  end
               end else begin
                  div_in = '0;
                  if (phase_ff == pcs_pkg::PH_READOUT) begin
                     ram_re        = 1'b1;
                     rp_in         = rp_next;
                     if (rp_next >= IB'(pcs_pkg::SAMPLES)) phase_in = pcs_pkg::PH_COMPLETE;
                     a_valid_in    = 1'b1;
                     a_kind_in     = pcs_pkg::KIND_SAMPLE;
                     a_index_in    = rp_ff;
                     a_from_mem_in = 1'b1;
                  end
               end
            end
            pcs_pkg::CMD_CONTROL: begin
               a_valid_in = 1'b1;
               if (is_idle) begin
                  case (code)
                     pcs_pkg::CTL_CAPTURE: begin
                        pre_in   = pre_total_ff;
                        post_in  = NB'(pcs_pkg::SAMPLES) - pre_total_ff;
                        phase_in = pcs_pkg::PH_ARMED;
                     end
                     pcs_pkg::CTL_READOUT: begin
                        rp_in    = '0;
                        phase_in = pcs_pkg::PH_READOUT;
                     end
                     pcs_pkg::CTL_DAQ: begin
                        rp_in    = '0;
                        phase_in = pcs_pkg::PH_DAQ;
                     end
                     default: a_status_in = pcs_pkg::ST_INVALID;
                  endcase
               end else if (code == pcs_pkg::CTL_STOP) begin
                  phase_in = pcs_pkg::PH_STOP;
               end else begin
                  a_status_in = pcs_pkg::ST_BUSY;
               end
            end
            pcs_pkg::CMD_STATUS: a_valid_in = 1'b1;
            default: ;
         endcase
      end
      a_state_in = phase_in;
   end

   always_comb begin
      b_valid_in = a_advance ? 1'b1 : (rsp_tready ? 1'b0 : b_valid_ff);
      for (int j = 0; j < pcs_pkg::OUT_CHANNELS; j++) begin
         b_chan_in[j] = a_from_mem_ff ? '0 : a_chan_ff[j];
      end
      if (a_from_mem_ff && a_row_ok_ff) begin
         for (int j = 0; j < pcs_pkg::CHANNELS; j++) begin
            b_chan_in[j] = CB'($signed(ram_q[j*SB +: SB]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_m1_ff     <= '0;
         pre_total_ff  <= '0;
         trig_sel_ff   <= '0;
         trig_level_ff <= '0;
         phase_ff      <= pcs_pkg::PH_STOP;
         wp_ff         <= '0;
         div_ff        <= '0;
         pre_ff        <= '0;
         post_ff       <= '0;
         rp_ff         <= '0;
         row_valid_ff  <= '0;
         a_valid_ff    <= 1'b0;
         b_valid_ff    <= 1'b0;
      end else begin
         div_m1_ff     <= div_m1_in;
         pre_total_ff  <= pre_total_in;
         trig_sel_ff   <= trig_sel_in;
         trig_level_ff <= trig_level_in;
         phase_ff      <= phase_in;
         wp_ff         <= wp_in;
         div_ff        <= div_in;
         pre_ff        <= pre_in;
         post_ff       <= post_in;
         rp_ff         <= rp_in;
         if (ram_we) begin
            row_valid_ff[wp_ff] <= 1'b1;
         end
         a_valid_ff    <= a_valid_in;
         b_valid_ff    <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_kind_ff     <= a_kind_in;
         a_status_ff   <= a_status_in;
         a_state_ff    <= a_state_in;
         a_index_ff    <= a_index_in;
         a_from_mem_ff <= a_from_mem_in;
         a_row_ok_ff   <= a_row_ok_in;
         a_chan_ff     <= a_chan_in;
      end
      if (a_advance) begin
         b_kind_ff   <= a_kind_ff;
         b_status_ff <= a_status_ff;
         b_state_ff  <= a_state_ff;
         b_index_ff  <= a_index_ff;
         b_chan_ff   <= b_chan_in;
      end
   end

   pcs_ram #(
      .WIDTH (pcs_pkg::ROW_BITS),
      .DEPTH (pcs_pkg::SAMPLES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wp_ff),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   assign rsp_tvalid = b_valid_ff;
   assign rsp_tuser  = b_kind_ff;
   assign rsp_tdata  = {3'b000, b_chan_ff[3], b_chan_ff[2], b_chan_ff[1], b_chan_ff[0],
                        b_index_ff, b_state_ff, b_status_ff};

   `ASSERT_IMPLY(a_no_rw_overlap, clock, reset, ram_we, !ram_re)
   `ASSERT_IMPLY(a_readout_pos, clock, reset, phase_ff == pcs_pkg::PH_READOUT,
                 rp_ff < IB'(pcs_pkg::SAMPLES))
   `ASSERT_NEXT(a_stage_holds, clock, reset, a_valid_ff && b_valid_ff && !rsp_tready,
                a_valid_ff && b_valid_ff)

endmodule

// File: tb/sv/pretrigger_capture_scope_core_tb.sv
// Self-checking testbench for pretrigger_capture_scope_core: directed and random requests vs. a predictor.
module pretrigger_capture_scope_core_tb;
   import pcs_pkg::*;

   localparam logic [1:0]  CMD_UNUSED      = 2'd3;
   localparam logic [31:0] LEVEL_MIN       = 32'h8000_0000;
   localparam logic [31:0] LEVEL_MAX       = 32'h7fff_ffff;
   localparam int          RANDOM_REQUESTS = 450;
   localparam int          SETTLE_CYCLES   = 4;
   localparam int          REPORT_LIMIT    = 50;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [2:0]        code;
      logic              sink;
      logic [3:0][31:0]  ch;
   } scope_req_t;

   typedef struct packed {
      kind_type          kind;
      status_type        status;
      phase_type         state;
      logic [15:0]       index;
      logic [3:0][31:0]  ch;
   } scope_rec_t;

   typedef struct packed {
      logic [2:0]        pad;
      logic [3:0][31:0]  ch;
      logic [15:0]       index;
      logic [2:0]        state;
      logic [1:0]        status;
   } rsp_word_t;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [REQ_DATA_BITS-1:0]     req_tdata = '0;
   logic [1:0]                   req_tuser = '0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]     rsp_tdata;
   logic                         rsp_tuser;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [CSR_IDX_BITS-1:0]      csr_index = '0;
   logic [CSR_DATA_BITS-1:0]     csr_data = '0;

   pretrigger_capture_scope_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // predictor state
   phase_type               ph;
   logic [ADDR_BITS-1:0]    wr_ptr;
   logic [15:0]             div_cnt;
   logic [8:0]              pre_left;
   logic [8:0]              post_left;
   logic [15:0]             rd_pos;
   logic [31:0]             capture_mem [SAMPLES][CHANNELS];
   logic [15:0]             cfg_div;
   logic [6:0]              cfg_pct;
   logic signed [3:0]       cfg_sel;
   logic signed [31:0]      cfg_level;

   scope_rec_t              pending_records [$];
   int                      tx_burst = 0;
   int                      mismatches = 0;
   int                      n_requests = 0;
   int                      n_results = 0;
   int                      n_captures = 0;
   int                      n_readouts = 0;
   logic [31:0]             rx_pattern = '1;
   logic [4:0]              rx_step = '0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #40000000;
      $display("DONE: errors detected");
      $finish;
   end

   // receiver backpressure: a fresh stall pattern each time the 5-bit step counter wraps
   always @(posedge clock) begin
      if (rx_step == 5'd31) begin
         case ($urandom_range(0, 3))
            0: rx_pattern <= '1;
            1: rx_pattern <= $urandom;
            default: rx_pattern <= $urandom | $urandom;
         endcase
      end
      rx_step <= rx_step + 5'd1;
      rsp_tready <= rx_pattern[rx_step];
   end

   function automatic bit scope_idle();
      return ph == PH_STOP || ph == PH_COMPLETE;
   endfunction

   function automatic void reset_scope_model();
      ph = PH_STOP;
      wr_ptr = '0;
      div_cnt = '0;
      pre_left = '0;
      post_left = '0;
      rd_pos = '0;
      cfg_div = '0;
      cfg_pct = '0;
      cfg_sel = '0;
      cfg_level = '0;
      for (int i = 0; i < SAMPLES; i++)
         for (int j = 0; j < CHANNELS; j++)
            capture_mem[i][j] = '0;
   endfunction

   function automatic void apply_reg(input reg_index_type idx, input logic [31:0] data);
      if (!scope_idle())
         return;
      case (idx)
         REG_DIVIDER: cfg_div = data[15:0];
         REG_PRETRIG: cfg_pct = data[6:0];
         REG_SELECT:  cfg_sel = data[3:0];
         REG_LEVEL:   cfg_level = data;
         default: ;
      endcase
   endfunction

   function automatic void sample_tick(input scope_req_t r, inout scope_rec_t rec, inout bit has);
      int sel_ch;
      if (div_cnt != 0) begin
         div_cnt = div_cnt - 16'd1;
         return;
      end
      div_cnt = cfg_div;
      for (int j = 0; j < CHANNELS; j++)
         capture_mem[wr_ptr][j] = r.ch[j];
      if (ph == PH_ARMED) begin
         if (pre_left != 0)
            pre_left = pre_left - 9'd1;
         else
            ph = PH_READY;
      end
      if (ph == PH_READY) begin
         sel_ch = (cfg_sel < 0) ? -int'(cfg_sel) - 1 : int'(cfg_sel) - 1;
         if (cfg_sel == 0) begin
            ph = PH_TRIGGERED;
         end else if (sel_ch < CHANNELS) begin
            if (cfg_sel < 0) begin
               if ($signed(r.ch[sel_ch]) <= cfg_level)
                  ph = PH_TRIGGERED;
            end else if ($signed(r.ch[sel_ch]) >= cfg_level) begin
               ph = PH_TRIGGERED;
            end
         end
      end
      if (ph == PH_TRIGGERED) begin
         if (post_left != 0)
            post_left = post_left - 9'd1;
         else
            ph = PH_COMPLETE;
      end
      if (ph == PH_DAQ) begin
         rec.kind = KIND_SAMPLE;
         rec.index = rd_pos;
         for (int j = 0; j < CHANNELS; j++)
            rec.ch[j] = capture_mem[wr_ptr][j];
         has = 1'b1;
         rd_pos = rd_pos + 16'd1;
      end
      wr_ptr = wr_ptr + 1'b1;
   endfunction

   function automatic void advance_scope(input scope_req_t r, output scope_rec_t rec,
                                         output bit has);
      int pos;
      int pct;
      logic [ADDR_BITS-1:0] row;
      status_type status;
      rec = '0;
      has = 1'b0;
      case (r.cmd)
         CMD_TICK: begin
            if (ph == PH_ARMED || ph == PH_READY || ph == PH_TRIGGERED || ph == PH_DAQ) begin
               sample_tick(r, rec, has);
            end else begin
               div_cnt = '0;
               if (ph == PH_READOUT) begin
                  pos = (rd_pos < SAMPLES) ? int'(rd_pos) : 0;
                  row = ADDR_BITS'(pos + int'(wr_ptr));
                  rec.kind = KIND_SAMPLE;
                  rec.index = rd_pos;
                  for (int j = 0; j < CHANNELS; j++)
                     rec.ch[j] = capture_mem[row][j];
                  if (r.sink)
                     rd_pos = rd_pos + 16'd1;
                  if (rd_pos >= SAMPLES)
                     ph = PH_COMPLETE;
                  has = 1'b1;
               end
            end
         end
         CMD_CONTROL: begin
            status = ST_OK;
            if (scope_idle()) begin
               case (r.code)
                  CTL_CAPTURE: begin
                     pct = (cfg_pct > PCT_MAX) ? PCT_MAX : int'(cfg_pct);
                     pre_left = 9'(pct * SAMPLES / PCT_MAX);
                     post_left = 9'(SAMPLES) - pre_left;
                     ph = PH_ARMED;
                  end
                  CTL_READOUT: begin
                     rd_pos = '0;
                     ph = PH_READOUT;
                  end
                  CTL_DAQ: begin
                     rd_pos = '0;
                     ph = PH_DAQ;
                  end
                  default: status = ST_INVALID;
               endcase
            end else if (r.code == CTL_STOP) begin
               ph = PH_STOP;
            end else begin
               status = ST_BUSY;
            end
            rec.kind = KIND_STATUS;
            rec.status = status;
            has = 1'b1;
         end
         CMD_STATUS: begin
            rec.kind = KIND_STATUS;
            has = 1'b1;
         end
         default: ;
      endcase
      rec.state = ph;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $error("%s: expected %0h, got %0h", name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      rsp_word_t got;
      scope_rec_t want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         got = rsp_word_t'(rsp_tdata);
         if (pending_records.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $error("result with no request outstanding");
         end else begin
            want = pending_records.pop_front();
            n_results++;
            check_field("record_kind", want.kind, rsp_tuser);
            check_field("status_code", want.status, got.status);
            check_field("scope_state", want.state, got.state);
            check_field("sample_index", want.index, got.index);
            for (int j = 0; j < 4; j++)
               check_field($sformatf("out_channel_%0d", j), want.ch[j], got.ch[j]);
         end
      end
   end

   function automatic logic [31:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return LEVEL_MIN;
         1: return LEVEL_MAX;
         2: return cfg_level - 32'd2 + 32'($urandom_range(0, 4));
         3: return cfg_level;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_level();
      case ($urandom_range(0, 3))
         0: return LEVEL_MIN;
         1: return LEVEL_MAX;
         2: return 32'($urandom_range(0, 64)) - 32'd32;
         default: return $urandom;
      endcase
   endfunction

   function automatic scope_req_t make_noise();
      scope_req_t r;
      r.cmd = 2'($urandom);
      r.code = 3'($urandom);
      r.sink = 1'($urandom);
      for (int j = 0; j < 4; j++)
         r.ch[j] = pick_sample();
      return r;
   endfunction

   function automatic scope_req_t make_tick(input logic sink);
      scope_req_t r;
      r = make_noise();
      r.cmd = CMD_TICK;
      r.sink = sink;
      return r;
   endfunction

   function automatic scope_req_t make_ctl(input logic [2:0] code);
      scope_req_t r;
      r = make_noise();
      r.cmd = CMD_CONTROL;
      r.code = code;
      return r;
   endfunction

   function automatic scope_req_t make_status();
      scope_req_t r;
      r = make_noise();
      r.cmd = CMD_STATUS;
      return r;
   endfunction

   task automatic send_req(input scope_req_t r);
      scope_rec_t rec;
      bit has;
      int gap;
      if (tx_burst == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         tx_burst = $urandom_range(1, 32);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      tx_burst--;
      req_tvalid <= 1'b1;
      req_tuser <= r.cmd;
      req_tdata <= REQ_DATA_BITS'({r.ch, r.sink, r.code});
      do @(posedge clock); while (req_tready !== 1'b1);
      advance_scope(r, rec, has);
      if (has)
         pending_records.push_back(rec);
      if (r.cmd != CMD_UNUSED)
         n_requests++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      tx_burst = 0;
      while (pending_records.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic go_idle();
      if (!scope_idle())
         send_req(make_ctl(CTL_STOP));
   endtask

   task automatic program_regs(input logic [15:0] div, input logic [6:0] pct,
                               input logic [3:0] sel, input logic [31:0] level);
      logic [31:0] data [4];
      go_idle();
      drain_results();
      data[REG_DIVIDER] = {16'($urandom), div};
      data[REG_PRETRIG] = {25'($urandom), pct};
      data[REG_SELECT]  = {28'($urandom), sel};
      data[REG_LEVEL]   = level;
      csr_valid <= 1'b1;
      for (int i = 0; i < 4; i++) begin
         csr_index <= CSR_IDX_BITS'(i);
         csr_data <= data[i];
         do @(posedge clock); while (csr_ready !== 1'b1);
         apply_reg(reg_index_type'(i), data[i]);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic program_random_regs();
      logic [15:0] div;
      logic [6:0] pct;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: div = '0;
         6, 7, 8: div = 16'($urandom_range(1, 3));
         default: div = 16'($urandom);
      endcase
      case ($urandom_range(0, 5))
         0: pct = '0;
         1: pct = 7'(PCT_MAX);
         2: pct = '1;
         default: pct = 7'($urandom);
      endcase
      program_regs(div, pct, 4'($urandom), pick_level());
   endtask

   task automatic run_capture(input int limit);
      int n;
      n = 0;
      go_idle();
      send_req(make_ctl(CTL_CAPTURE));
      while (ph != PH_COMPLETE && n < limit) begin
         case ($urandom_range(0, 31))
            0: send_req(make_status());
            1: send_req(make_ctl(3'($urandom_range(1, 7))));
            default: send_req(make_tick(1'($urandom)));
         endcase
         n++;
      end
      if (ph == PH_COMPLETE)
         n_captures++;
      else
         go_idle();
   endtask

   task automatic run_readout(input int limit);
      int n;
      n = 0;
      go_idle();
      send_req(make_ctl(CTL_READOUT));
      while (ph == PH_READOUT && n < limit) begin
         case ($urandom_range(0, 19))
            0: send_req(make_status());
            1: send_req(make_ctl(3'($urandom_range(1, 7))));
            default: send_req(make_tick($urandom_range(0, 3) != 0));
         endcase
         n++;
      end
      if (ph == PH_COMPLETE)
         n_readouts++;
      else
         go_idle();
   endtask

   task automatic run_daq(input int ticks);
      int n;
      n = 0;
      go_idle();
      send_req(make_ctl(CTL_DAQ));
      while (n < ticks) begin
         if ($urandom_range(0, 31) == 0) begin
            send_req(make_status());
         end else begin
            send_req(make_tick(1'($urandom)));
            n++;
         end
      end
      go_idle();
   endtask

   function automatic int capture_budget();
      return (cfg_div > 3) ? 40 : 400 * (int'(cfg_div) + 1);
   endfunction

   function automatic int clamp_to(input int want, input int left);
      return (want < left) ? want : left;
   endfunction

   task automatic test_directed_commands();
      scope_req_t r;
      send_req(make_status());
      send_req(make_tick(1'b1));
      r = make_noise();
      r.cmd = CMD_UNUSED;
      send_req(r);
      for (int c = 0; c < 8; c++)
         if (c != CTL_CAPTURE && c != CTL_READOUT && c != CTL_DAQ)
            send_req(make_ctl(3'(c)));
      send_req(make_ctl(CTL_DAQ));
      r = make_tick(1'b0);
      r.ch = {32'hffff_ffff, 32'd0, LEVEL_MAX, LEVEL_MIN};
      send_req(r);
      r.ch = {LEVEL_MIN, LEVEL_MAX, 32'd0, 32'hffff_ffff};
      r.sink = 1'b1;
      r.code = 3'h7;
      send_req(r);
      for (int c = 1; c < 8; c++)
         send_req(make_ctl(3'(c)));
      send_req(make_ctl(CTL_STOP));
      send_req(make_ctl(CTL_READOUT));
      send_req(make_tick(1'b0));
      send_req(make_tick(1'b1));
      send_req(make_ctl(CTL_STOP));
      send_req(make_ctl(CTL_CAPTURE));
      send_req(make_tick(1'b0));
      send_req(make_status());
      send_req(make_ctl(CTL_STOP));
   endtask

   task automatic test_register_extremes();
      // slowest divider: one record, the rest decimated
      program_regs(16'hffff, 7'h7f, 4'd0, LEVEL_MAX);
      run_daq(6);
      run_capture(4);
      // pretrigger above 100 saturates, immediate trigger
      program_regs(16'd0, 7'h7f, 4'd0, 32'd0);
      run_capture(600);
      run_readout(2000);
      // first channel (channel_0) at or below the most negative level
      program_regs(16'd0, 7'd0, 4'(-1), LEVEL_MIN);
      run_capture(400);
      program_regs(16'd1, 7'(PCT_MAX), 4'd4, LEVEL_MAX);
      run_capture(60);
   endtask

   task automatic test_trigger_selects();
      int n;
      for (int s = -8; s <= 7; s++) begin
         program_regs(16'($urandom_range(0, 1)), 7'd0, 4'(s), pick_level());
         send_req(make_ctl(CTL_CAPTURE));
         n = 0;
         while ((ph == PH_ARMED || ph == PH_READY) && n < 20) begin
            send_req(make_tick(1'b0));
            n++;
         end
         send_req(make_status());
         go_idle();
      end
   endtask

   task automatic test_random_traffic();
      int first;
      int left;
      first = n_requests;
      left = RANDOM_REQUESTS;
      while (left > 0) begin
         if ($urandom_range(0, 3) == 0)
            program_random_regs();
         case ($urandom_range(0, 9))
            0, 1, 2: run_capture(clamp_to(capture_budget(), left));
            3, 4: run_readout(clamp_to(2000, left));
            5: run_readout(clamp_to($urandom_range(1, 40), left));
            6: run_daq(clamp_to($urandom_range(1, 60), left));
            7: run_capture(clamp_to($urandom_range(1, 50), left));
            default: repeat (clamp_to($urandom_range(1, 10), left)) send_req(make_noise());
         endcase
         left = RANDOM_REQUESTS - (n_requests - first);
      end
   endtask

   initial begin
      reset_scope_model();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed_commands();
      test_register_extremes();
      test_trigger_selects();
      test_random_traffic();
      drain_results();
      $display("Covered %0d requests, %0d results checked, %0d full captures, %0d full readouts",
               n_requests, n_results, n_captures, n_readouts);
      $display("Trigger selects -8..7, divider and pretrigger extremes, DAQ and readout runs");
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
